>>> rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared constants, round functions and the control types passed between
// the hasher sequencer and the compression unit.
// ----------------------------------------------------------------------------
package shs_pkg;

    // Byte appended after the message, and the block position of the length.
    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [63:0] BYTE_BITS = 64'd8;
    localparam logic [2:0]  LAST_WORD = 3'd7;
    localparam logic [2:0]  LAST_LEN_BYTE = 3'd7;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [5:0]  LAST_BYTE  = 6'd63;

    // Initial hash values.
    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    // Round constants.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Requests from the sequencer to the compression unit.
    typedef struct packed {
        logic       start;
        logic       init_chain;
        logic       wr_en;
        logic [5:0] wr_idx;
        logic [7:0] wr_data;
    } t_cmp_ctrl;

    // Status returned by the compression unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_cmp_status;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        rotr32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/shs_byte_if.sv
// ----------------------------------------------------------------------------
// SHA-256 byte channel
// Valid/ready channel carrying one message byte and its framing flags.
// ----------------------------------------------------------------------------
interface shs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       carries_byte;
    logic       ends_message;

    modport source (output valid, output byte_value, output carries_byte,
                    output ends_message, input ready);
    modport sink   (input valid, input byte_value, input carries_byte,
                    input ends_message, output ready);
endinterface

>>> rtl/shs_word_if.sv
// ----------------------------------------------------------------------------
// SHA-256 digest channel
// Valid/ready channel carrying one 32-bit digest word and its position.
// ----------------------------------------------------------------------------
interface shs_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

>>> rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Takes a message at most one byte per transfer, pads it on the end flag and returns
// the eight digest words, most significant first.
// ----------------------------------------------------------------------------
// A byte that does not fill a block leaves the input ready for the next one.
// A byte that fills a block holds the input off through the load, the 64 rounds,
// the chain update and the completion pulse from the round unit.
// An ending transfer is followed by the padding mark, the zero bytes and the
// length bytes, each compression on the way, then eight output transfers.
// Synchronous active-low reset restores the initial hash and a zero length.
module sha256_stream_hasher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    shs_byte_if.sink         i_in,
    shs_word_if.source       o_out
);
    import shs_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MARK, S_ZERO, S_LEN, S_WAIT, S_OUT} t_state;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [63:0] r_bit_len, n_bit_len;
    logic [5:0]  r_byte_idx, n_byte_idx;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_len_cnt, n_len_cnt;
    logic [2:0]  r_word, n_word;
    logic        r_start, n_start;

    logic        w_in_xfer;
    logic        w_out_xfer;
    logic        w_put;
    logic [7:0]  w_put_data;
    logic        w_init;
    logic [63:0] w_len_add;

    t_cmp_ctrl   w_ctrl;
    t_cmp_status w_sts;
    logic [31:0] w_chain [8];

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_xfer  = o_out.valid && o_out.ready;
    assign w_len_add   = i_in.carries_byte ? BYTE_BITS : 64'd0;

    // Sequencer: message bytes, padding, length, compression waits, output.
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_bit_len  = r_bit_len;
        n_byte_idx = r_byte_idx;
        n_len      = r_len;
        n_len_cnt  = r_len_cnt;
        n_word     = r_word;
        n_start    = 1'b0;
        w_put      = 1'b0;
        w_put_data = '0;
        w_init     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_put      = i_in.carries_byte;
                    w_put_data = i_in.byte_value;
                    n_bit_len  = r_bit_len + w_len_add;
                    if (i_in.ends_message) begin
                        n_len     = r_bit_len + w_len_add;
                        n_len_cnt = '0;
                        n_state   = S_MARK;
                    end
                end
            end
            S_MARK: begin
                w_put      = 1'b1;
                w_put_data = PAD_MARK;
                n_state    = S_ZERO;
            end
            S_ZERO: begin
                if (r_byte_idx == LEN_POS) begin
                    n_state = S_LEN;
                end else begin
                    w_put = 1'b1;
                end
            end
            S_LEN: begin
                w_put      = 1'b1;
                w_put_data = r_len[63:56];
                n_len      = {r_len[55:0], 8'd0};
                n_len_cnt  = r_len_cnt + 3'd1;
                if (r_len_cnt == LAST_LEN_BYTE) begin
                    n_state = S_OUT;
                end
            end
            S_WAIT: begin
                if (w_sts.done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_word = r_word + 3'd1;
                    if (r_word == LAST_WORD) begin
                        w_init     = 1'b1;
                        n_bit_len  = '0;
                        n_byte_idx = '0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A byte that completes a block starts a compression and parks the
        // sequencer until it finishes.
        if (w_put) begin
            n_byte_idx = r_byte_idx + 6'd1;
            if (r_byte_idx == LAST_BYTE) begin
                n_ret   = n_state;
                n_state = S_WAIT;
                n_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_bit_len  <= '0;
            r_byte_idx <= '0;
            r_len_cnt  <= '0;
            r_word     <= '0;
            r_start    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_bit_len  <= n_bit_len;
            r_byte_idx <= n_byte_idx;
            r_len_cnt  <= n_len_cnt;
            r_word     <= n_word;
            r_start    <= n_start;
        end
    end

    // Latched length is payload only.
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    // Requests to the compression unit.
    always_comb begin
        w_ctrl.start      = r_start;
        w_ctrl.init_chain = w_init;
        w_ctrl.wr_en      = w_put;
        w_ctrl.wr_idx     = r_byte_idx;
        w_ctrl.wr_data    = w_put_data;
    end

    shs_compress u_compress (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .o_status (w_sts),
        .o_chain  (w_chain)
    );

    // Digest words are read straight from the chain value.
    assign o_out.digest_word = w_chain[r_word];
    assign o_out.word_index  = r_word;
    assign o_out.last_word   = (r_word == LAST_WORD);

    // A byte is never written into the store while a compression runs.
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_put |-> !w_sts.busy)
        else $error("byte written while compression unit busy");

    // Completion only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_WAIT))
        else $error("compression finished outside the wait state");

    // The digest is only offered on a block boundary with the unit idle.
    a_out_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_byte_idx == '0 && !w_sts.busy))
        else $error("digest offered mid-block or during compression");

    // The last word transfer re-arms the block for a fresh message.
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_out.last_word) |=> (r_state == S_IDLE && r_bit_len == '0))
        else $error("block not re-initialised after the digest");

endmodule

>>> rtl/shs_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// Holds the block store, the working variables and the chain value, and runs
// one round per cycle: load, 64 rounds, chain update.
// ----------------------------------------------------------------------------
module shs_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shs_pkg::t_cmp_ctrl  i_ctrl,
    output shs_pkg::t_cmp_status o_status,
    output logic [31:0]         o_chain [8]
);
    import shs_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FINAL} t_cmp_state;

    t_cmp_state  r_state;
    logic [5:0]  r_round;
    logic        r_done;
    logic [31:0] r_chain [8];
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];

    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_sched;

    // Round logic: one SHA-256 round on the working variables.
    always_comb begin
        w_t1 = r_v[7] + big_sigma1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + ROUND_K[r_round] + r_w[0];
        w_t2 = big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        w_sched = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    end

    // Sequencer, chain value and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < 8; i++) r_chain[i] <= INIT_CHAIN[i];
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_ctrl.init_chain) begin
                        for (int i = 0; i < 8; i++) r_chain[i] <= INIT_CHAIN[i];
                    end
                    if (i_ctrl.start) begin
                        r_state <= C_ROUND;
                        r_round <= '0;
                    end
                end
                C_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= C_FINAL;
                    end
                end
                C_FINAL: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    // Block store and working variables; the store doubles as the schedule
    // window and shifts by one word each round.
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_ctrl.wr_en) begin
            if (i_ctrl.wr_idx[1:0] == 2'd0) begin
                r_w[i_ctrl.wr_idx[5:2]] <= {i_ctrl.wr_data, 24'd0};
            end else begin
                r_w[i_ctrl.wr_idx[5:2]][(6'd31 - {1'b0, i_ctrl.wr_idx[1:0], 3'd0}) -: 8]
                    <= i_ctrl.wr_data;
            end
        end
        if (r_state == C_IDLE && i_ctrl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
        end
        if (r_state == C_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_sched;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    assign o_status.busy = (r_state != C_IDLE);
    assign o_status.done = r_done;
    assign o_chain       = r_chain;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte messages through the valid/ready byte channel. A short table of
// directed items comes first. Random messages follow, with lengths clustered
// around the padding boundaries and scattered empty items among them. Every
// accepted byte goes into a local SHA-256 model; each output digest word is
// checked against it or a typed-in digest. Random idle cycles fall on both sides.
// ----------------------------------------------------------------------------
module testbench;

    // One expected digest word, as it should appear on the output channel.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_entry;

    // One row of the directed table; the digest is typed in only when known.
    typedef struct packed {
        logic [7:0]   byte_value;
        logic         carries_byte;
        logic         ends_message;
        logic         has_digest;
        logic [255:0] digest;
    } t_stim_row;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_OFFSET    = 6'd56;
    localparam int         RANDOM_ITEMS  = 330;
    localparam int         IDLE_PERCENT  = 26;
    localparam int         DRAIN_CYCLES  = 300;
    localparam int         BOUNDARY_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic i_clk;
    logic i_rst_n;

    shs_byte_if byte_ch ();
    shs_word_if word_ch ();

    sha256_stream_hasher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (word_ch)
    );

    // Local hash state: chain value, partly filled block and message length.
    logic [31:0] chain_h [8];
    logic [31:0] block_w [16];
    logic [5:0]  block_fill;
    logic [63:0] msg_bits;

    t_digest_entry digest_q [$];
    t_stim_row     directed [$];
    int unsigned   fault_count;
    int unsigned   items_sent;
    logic          quiet;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if the hasher stops making progress.
    initial begin
        #3_000_000;
        $display("sha256_stream_hasher: mismatch");
        $finish;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    // Runs the 64 rounds over the block store and folds the result into the chain.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, ch, maj, t1;
        int i;
        for (i = 0; i < 16; i++) w[i] = block_w[i];
        for (i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (i = 0; i < 8; i++) v[i] = chain_h[i];
        for (i = 0; i < 64; i++) begin
            s1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + RK[i] + w[i];
            s0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + s0 + maj;
        end
        for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endtask

    // Packs one byte big-endian into the block; a full block is compressed.
    task automatic absorb_byte(input logic [7:0] b);
        int lane;
        lane = 3 - block_fill[1:0];
        if (block_fill[1:0] == 2'd0) begin
            block_w[block_fill[5:2]] = 32'h0;
        end
        block_w[block_fill[5:2]][8*lane +: 8] = b;
        block_fill = block_fill + 6'd1;
        if (block_fill == 6'd0) begin
            compress_block();
        end
    endtask

    // Pads the message, queues the eight digest words and starts afresh.
    task automatic close_message(input logic typed, input logic [255:0] dig);
        logic [63:0]   len;
        t_digest_entry ent;
        int i;
        len = msg_bits;
        absorb_byte(PAD_BYTE);
        while (block_fill != LEN_OFFSET) absorb_byte(8'h00);
        for (i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
        for (i = 0; i < 8; i++) begin
            ent.digest_word = typed ? dig[255-32*i -: 32] : chain_h[i];
            ent.word_index  = 3'(i);
            ent.last_word   = (i == 7);
            digest_q.push_back(ent);
        end
        for (i = 0; i < 8; i++) chain_h[i] = IV[i];
        msg_bits   = 64'd0;
        block_fill = 6'd0;
    endtask

    // Drives one item from a falling edge and holds it until the transfer.
    task automatic send_item(input logic [7:0] b, input logic c, input logic e,
                             input logic typed, input logic [255:0] dig);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_value   <= b;
        byte_ch.carries_byte <= c;
        byte_ch.ends_message <= e;
        do @(posedge i_clk); while (!byte_ch.ready);
        if (c) begin
            absorb_byte(b);
            msg_bits = msg_bits + 64'd8;
        end
        if (e) begin
            close_message(typed, dig);
        end
        items_sent++;
        // A stretch in the middle of the run with no idle cycles on either side.
        quiet = (items_sent >= 120 && items_sent < 220);
        @(negedge i_clk);
    endtask

    // Output side: random back-pressure, changed at the falling edge.
    initial begin
        word_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            word_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Digest checker: each transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_digest_entry exp_w;
        if (i_rst_n && word_ch.valid && word_ch.ready) begin
            if (digest_q.size() == 0) begin
                fault_count++;
                $display("%0t: digest word with none expected: expected nothing, got %h",
                         $realtime, word_ch.digest_word);
            end else begin
                exp_w = digest_q.pop_front();
                if (word_ch.digest_word !== exp_w.digest_word) begin
                    fault_count++;
                    $display("%0t: digest_word expected %h, got %h",
                             $realtime, exp_w.digest_word, word_ch.digest_word);
                end
                if (word_ch.word_index !== exp_w.word_index) begin
                    fault_count++;
                    $display("%0t: word_index expected %0d, got %0d",
                             $realtime, exp_w.word_index, word_ch.word_index);
                end
                if (word_ch.last_word !== exp_w.last_word) begin
                    fault_count++;
                    $display("%0t: last_word expected %b, got %b",
                             $realtime, exp_w.last_word, word_ch.last_word);
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random messages.
    initial begin
        int i, k, msg_len, pick;
        logic fold_last;
        byte_ch.valid        = 1'b0;
        byte_ch.byte_value   = 8'h00;
        byte_ch.carries_byte = 1'b0;
        byte_ch.ends_message = 1'b0;
        i_rst_n     = 1'b0;
        quiet       = 1'b0;
        fault_count = 0;
        items_sent  = 0;
        for (i = 0; i < 8; i++) chain_h[i] = IV[i];
        for (i = 0; i < 16; i++) block_w[i] = 32'h0;
        block_fill = 6'd0;
        msg_bits   = 64'd0;

        // Empty item, ignored all-ones byte, then the empty message.
        directed.push_back('{8'h00, 1'b0, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'hff, 1'b0, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'h5a, 1'b0, 1'b1, 1'b1,
            256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855});
        // "abc", the last byte carried by the ending item.
        directed.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'h63, 1'b1, 1'b1, 1'b1,
            256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad});
        // Extreme bytes with an ignored byte between them, ended without a byte.
        directed.push_back('{8'h00, 1'b1, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'hff, 1'b1, 1'b0, 1'b0, 256'h0});
        directed.push_back('{8'h00, 1'b0, 1'b1, 1'b0, 256'h0});
        // One-byte message carried by the ending item itself.
        directed.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 256'h0});
        // End with an ignored byte value on the data lines.
        directed.push_back('{8'hc3, 1'b0, 1'b1, 1'b0, 256'h0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[row]) begin
            send_item(directed[row].byte_value, directed[row].carries_byte,
                      directed[row].ends_message, directed[row].has_digest,
                      directed[row].digest);
        end

        // Random messages: many short, many around the padding boundaries.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                msg_len = $urandom_range(0, 8);
            end else if (pick < 8) begin
                msg_len = BOUNDARY_LEN[$urandom_range(0, 8)];
            end else begin
                msg_len = $urandom_range(0, 130);
            end
            fold_last = (msg_len != 0) && ($urandom_range(0, 1) == 1);
            for (k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 256'h0);
                end
                send_item(8'($urandom_range(0, 255)), 1'b1,
                          fold_last && (k == msg_len - 1), 1'b0, 256'h0);
            end
            if (!fold_last) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 256'h0);
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain the outstanding digests, then watch for stray words.
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("sha256_stream_hasher: match");
        end else begin
            $display("sha256_stream_hasher: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/shs_pkg.sv
rtl/shs_byte_if.sv
rtl/shs_word_if.sv
rtl/shs_compress.sv
rtl/sha256_stream_hasher.sv
tb/testbench.sv
